// File: hdl/gcma_pkg.sv
// Package for the gravity compensated motion acceleration core.
// Holds widths, register indexes, controller command types and helper functions.
// Depends on nothing.
package gcma_pkg;

    localparam int unsigned FracQ = 28;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CfgLpfTime = 1'd0;
    localparam logic [CfgIdxW-1:0] CfgGravity = 1'd1;

    localparam logic [15:0] LpfTimeReset = 16'd8500;
    localparam logic [14:0] GravityReset = 15'd2511;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        t_S_IDLE   = 7'b0000001,
        t_S_MAT    = 7'b0000010,
        t_S_GRAV   = 7'b0000100,
        t_S_NUM    = 7'b0001000,
        t_S_DIV    = 7'b0010000,
        t_S_EARTH  = 7'b0100000,
        t_S_OUT    = 7'b1000000
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       load;      // capture input item
        logic       mat;       // compute matrix entry at idx
        logic       grav;      // gravity product at idx
        logic       num;       // filter numerator at idx
        logic       div_start; // start divider for idx
        logic       div_step;  // one divider step
        logic       div_done;  // store quotient at idx
        logic       earth;     // accumulate earth product row idx, col jdx
        logic [1:0] idx;
        logic [3:0] mdx;       // matrix entry index 0..8
        logic [1:0] jdx;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
    } t_status;

    // Saturate a 40 bit signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        if (v > 40'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Shift right by FracQ, rounding ties away from zero.
    function automatic logic signed [39:0] shr_round(input logic signed [63:0] v);
        logic [63:0] a;
        logic [63:0] s;
        logic signed [39:0] r;
        a = v[63] ? 64'(-v) : 64'(v);
        s = (a + (64'd1 << (FracQ - 1))) >> FracQ;
        r = v[63] ? -40'(signed'(s[39:0])) : 40'(signed'(s[39:0]));
        return r;
    endfunction

endpackage

// File: hdl/gcma_if.sv
// Valid/ready channel interfaces for the core.
// Depends on nothing.
interface gcma_in_if (input logic i_clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [15:0] dt_us;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y,
                    accel_z, dt_us, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, accel_x, accel_y,
                  accel_z, dt_us, output ready);
endinterface

interface gcma_out_if (input logic i_clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] motion_body_x;
    logic signed [15:0] motion_body_y;
    logic signed [15:0] motion_body_z;
    logic signed [15:0] motion_earth_x;
    logic signed [15:0] motion_earth_y;
    logic signed [15:0] motion_earth_z;
    modport source (output valid, motion_body_x, motion_body_y, motion_body_z,
                    motion_earth_x, motion_earth_y, motion_earth_z, input ready);
    modport sink (input valid, motion_body_x, motion_body_y, motion_body_z,
                  motion_earth_x, motion_earth_y, motion_earth_z, output ready);
endinterface

// File: hdl/gcma_ctrl.sv
// Controller state machine: sequences matrix, gravity, filter division and
// earth rotation steps. Depends on gcma_pkg.
module gcma_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output gcma_pkg::t_cmd     o_cmd,
    input  gcma_pkg::t_status  i_status
);
    import gcma_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;   // matrix entry index
    logic [1:0] r_idx, n_idx;
    logic [1:0] r_jdx, n_jdx;
    logic [5:0] r_step, n_step;

    assign o_in_ready  = (r_state == t_S_IDLE);
    assign o_out_valid = (r_state == t_S_OUT);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_jdx   = r_jdx;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.idx = r_idx;
        o_cmd.jdx = r_jdx;
        o_cmd.mdx = r_cnt;
        unique case (r_state)
            t_S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = t_S_MAT;
                    n_cnt = '0;
                end
            end
            t_S_MAT: begin
                o_cmd.mat = 1'b1;
                if (r_cnt == 4'd8) begin
                    n_state = t_S_GRAV;
                    n_idx = '0;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            t_S_GRAV: begin
                o_cmd.grav = 1'b1;
                if (r_idx == 2'd2) begin
                    n_idx = '0;
                    n_state = i_status.den_zero ? t_S_EARTH : t_S_NUM;
                    n_jdx = '0;
                end else begin
                    n_idx = r_idx + 2'd1;
                end
            end
            t_S_NUM: begin
                o_cmd.num = 1'b1;
                n_state = t_S_DIV;
                n_step = '0;
            end
            t_S_DIV: begin
                if (r_step == 6'd0) begin
                    o_cmd.div_start = 1'b1;
                    n_step = 6'd1;
                end else if (r_step == 6'd42) begin
                    o_cmd.div_done = 1'b1;
                    if (r_idx == 2'd2) begin
                        n_idx = '0;
                        n_jdx = '0;
                        n_state = t_S_EARTH;
                    end else begin
                        n_idx = r_idx + 2'd1;
                        n_state = t_S_NUM;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_step = r_step + 6'd1;
                end
            end
            t_S_EARTH: begin
                o_cmd.earth = 1'b1;
                if (r_jdx == 2'd2) begin
                    n_jdx = '0;
                    if (r_idx == 2'd2) begin
                        n_state = t_S_OUT;
                    end else begin
                        n_idx = r_idx + 2'd1;
                    end
                end else begin
                    n_jdx = r_jdx + 2'd1;
                end
            end
            t_S_OUT: begin
                if (i_out_ready) begin
                    n_state = t_S_IDLE;
                end
            end
            default: n_state = t_S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_jdx   <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_jdx   <= n_jdx;
            r_step  <= n_step;
        end
    end
endmodule

// File: hdl/gcma_dp.sv
// Datapath: rotation matrix, gravity projection, bit-serial filter division,
// earth rotation and state. Depends on gcma_pkg.
module gcma_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcma_pkg::t_cmd     i_cmd,
    output gcma_pkg::t_status  o_status,
    input  logic [15:0]        i_tau,
    input  logic [14:0]        i_grav,
    input  logic signed [15:0] i_q [4],
    input  logic signed [15:0] i_acc [3],
    input  logic [15:0]        i_dt,
    output logic signed [15:0] o_body [3],
    output logic signed [15:0] o_earth [3]
);
    import gcma_pkg::*;

    logic signed [15:0] r_q [4];
    logic signed [15:0] r_acc [3];
    logic [15:0]        r_dt;
    logic signed [33:0] r_m [9];        // Q28 matrix; any quaternion fits 34 bits signed
    logic signed [21:0] r_gb [3];       // up to about 2^19 for an unnormalized quaternion
    logic signed [15:0] r_filt [3];
    logic signed [63:0] r_sum;
    logic signed [15:0] r_earth [3];
    logic [16:0]        r_den;
    logic [41:0]        r_rem;          // partial remainder
    logic [40:0]        r_dvd;          // dividend magnitude shifted out
    logic [40:0]        r_quo;
    logic               r_neg;
    logic signed [40:0] r_num;

    assign o_status.den_zero = ({1'b0, i_tau} + {1'b0, r_dt}) == 17'd0;

    // Matrix entry for the selected index, two products of 16x16.
    logic signed [15:0] a0, b0, a1, b1;
    logic               sub, diag;
    always_comb begin
        a0 = r_q[1]; b0 = r_q[2]; a1 = r_q[0]; b1 = r_q[3]; sub = 1'b1; diag = 1'b0;
        case (i_cmd.mdx)
            4'd0: begin a0 = r_q[2]; b0 = r_q[2]; a1 = r_q[3]; b1 = r_q[3]; diag = 1'b1; end
            4'd1: begin a0 = r_q[1]; b0 = r_q[2]; a1 = r_q[0]; b1 = r_q[3]; sub = 1'b1; end
            4'd2: begin a0 = r_q[1]; b0 = r_q[3]; a1 = r_q[0]; b1 = r_q[2]; sub = 1'b0; end
            4'd3: begin a0 = r_q[1]; b0 = r_q[2]; a1 = r_q[0]; b1 = r_q[3]; sub = 1'b0; end
            4'd4: begin a0 = r_q[1]; b0 = r_q[1]; a1 = r_q[3]; b1 = r_q[3]; diag = 1'b1; end
            4'd5: begin a0 = r_q[2]; b0 = r_q[3]; a1 = r_q[0]; b1 = r_q[1]; sub = 1'b1; end
            4'd6: begin a0 = r_q[1]; b0 = r_q[3]; a1 = r_q[0]; b1 = r_q[2]; sub = 1'b1; end
            4'd7: begin a0 = r_q[2]; b0 = r_q[3]; a1 = r_q[0]; b1 = r_q[1]; sub = 1'b0; end
            4'd8: begin a0 = r_q[1]; b0 = r_q[1]; a1 = r_q[2]; b1 = r_q[2]; diag = 1'b1; end
            default: ;
        endcase
    end

    logic signed [33:0] p0, p1, mval;
    always_comb begin
        p0 = 34'(a0 * b0);
        p1 = 34'(a1 * b1);
        if (diag) begin
            mval = (34'sd1 <<< FracQ) - (p0 <<< 1) - (p1 <<< 1);
        end else if (sub) begin
            mval = (p0 - p1) <<< 1;
        end else begin
            mval = (p0 + p1) <<< 1;
        end
    end

    // One multiply of a matrix entry by a 17 bit signed value.
    logic signed [33:0] mul_m;
    logic signed [16:0] mul_v;
    logic signed [50:0] mul_p;
    always_comb begin
        mul_m = r_m[4'd6 + 4'(i_cmd.idx)];
        mul_v = 17'(signed'({2'b00, i_grav}));
        if (i_cmd.earth) begin
            mul_m = r_m[4'd3 * 4'(i_cmd.idx) + 4'(i_cmd.jdx)];
            mul_v = 17'(r_filt[i_cmd.jdx]);
        end
        mul_p = 51'(mul_m) * 51'(mul_v);
    end

    // Filter numerator d*dt + old*tau.
    logic signed [22:0] d;
    logic signed [40:0] num;
    always_comb begin
        d   = 23'(r_acc[i_cmd.idx]) - 23'(r_gb[i_cmd.idx]);
        num = 41'(d) * 41'(signed'({1'b0, r_dt}))
            + 41'(r_filt[i_cmd.idx]) * 41'(signed'({1'b0, i_tau}));
    end

    logic [41:0] trial;
    logic [40:0] mag;
    always_comb begin
        trial  = {r_rem[40:0], r_dvd[40]} - {25'd0, r_den};
        mag    = r_num[40] ? 41'(-r_num) : 41'(r_num);
    end

    logic signed [63:0] sum_next;
    assign sum_next = r_sum + 64'(mul_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_filt[k] <= '0;
        end else if (i_cmd.div_done) begin
            r_filt[i_cmd.idx] <= sat16(r_neg ? -40'(signed'({1'b0, r_quo[38:0]}))
                : 40'(signed'({1'b0, r_quo[38:0]})) );
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q   <= i_q;
            r_acc <= i_acc;
            r_dt  <= i_dt;
        end
        if (i_cmd.mat) r_m[i_cmd.mdx] <= mval;
        if (i_cmd.grav) r_gb[i_cmd.idx] <= 22'(shr_round(64'(mul_p)));
        if (i_cmd.num) r_num <= num;
        // Restoring division of |num| + den/2 by den, one bit a cycle.
        if (i_cmd.div_start) begin
            r_den <= {1'b0, i_tau} + {1'b0, r_dt};
            r_neg <= r_num[40];
            r_dvd <= mag + 41'(({1'b0, i_tau} + {1'b0, r_dt}) >> 1);
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[39:0], 1'b0};
            if (!trial[41]) begin
                r_rem <= trial;
                r_quo <= {r_quo[39:0], 1'b1};
            end else begin
                r_rem <= {r_rem[40:0], r_dvd[40]};
                r_quo <= {r_quo[39:0], 1'b0};
            end
        end
        // Earth row accumulation.
        if (i_cmd.earth) begin
            if (i_cmd.jdx == 2'd2) begin
                r_earth[i_cmd.idx] <= sat16(shr_round(sum_next));
                r_sum <= '0;
            end else begin
                r_sum <= sum_next;
            end
        end else begin
            r_sum <= '0;
        end
    end

    assign o_body  = r_filt;
    assign o_earth = r_earth;
    logic unused;
    assign unused = ^{r_quo[40:39], r_rem[41]};
endmodule

// File: hdl/gravity_compensated_motion_accel_core.sv
// Gravity compensated motion acceleration core.
// Accepts one item on s_in (quaternion Q1.14, acceleration Q7.8, dt in us),
// removes gravity rotated into the body frame, low-pass filters the result
// with weight dt/(tau+dt) and gives the filtered body value and its earth
// frame rotation on m_out.
// Steps: matrix entries, gravity, then per axis a numerator step and a 41
// bit restoring divider (one quotient bit a cycle), then earth rotation.
// When tau+dt is zero the numerator and divider steps are skipped and the
// state is held. One item at a time; the next item is taken the cycle after
// the result is taken. The divider sets the rate.
// Reset (synchronous, i_rst_n low) clears the filter state to zero and sets
// tau to 8500 us and gravity to 2511. When the receiver stalls, the result
// holds in the output registers and no new item is accepted.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must do so only while idle, since the block itself does not enforce it.
// Depends on gcma_pkg, gcma_if, gcma_ctrl and gcma_dp.
module gravity_compensated_motion_accel_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gcma_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [gcma_pkg::CfgDataW-1:0] i_cfg_data,
    gcma_in_if.sink                    s_in,
    gcma_out_if.source                 m_out
);
    import gcma_pkg::*;

    logic [15:0] r_tau;
    logic [14:0] r_grav;
    t_cmd        cmd;
    t_status     status;
    logic signed [15:0] q [4];
    logic signed [15:0] acc [3];
    logic signed [15:0] body [3];
    logic signed [15:0] earth [3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau  <= LpfTimeReset;
            r_grav <= GravityReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgLpfTime: r_tau  <= i_cfg_data;
                CfgGravity: r_grav <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign q   = '{s_in.quat_w, s_in.quat_x, s_in.quat_y, s_in.quat_z};
    assign acc = '{s_in.accel_x, s_in.accel_y, s_in.accel_z};

    gcma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_in.valid),
        .o_in_ready  (s_in.ready),
        .o_out_valid (m_out.valid),
        .i_out_ready (m_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    gcma_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_tau    (r_tau),
        .i_grav   (r_grav),
        .i_q      (q),
        .i_acc    (acc),
        .i_dt     (s_in.dt_us),
        .o_body   (body),
        .o_earth  (earth)
    );

    assign m_out.motion_body_x  = body[0];
    assign m_out.motion_body_y  = body[1];
    assign m_out.motion_body_z  = body[2];
    assign m_out.motion_earth_x = earth[0];
    assign m_out.motion_earth_y = earth[1];
    assign m_out.motion_earth_z = earth[2];
endmodule

// File: dv/gcma_scoreboard.sv
// Checker for the gravity compensated motion acceleration core.
// Watches the configuration port and both channels, predicts each result and compares.
// Depends on gcma_pkg and gcma_if.
`timescale 1ns / 100ps

module gcma_scoreboard (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [gcma_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [gcma_pkg::CfgDataW-1:0] i_cfg_data,
    gcma_in_if          in_if,
    gcma_out_if         out_if,
    output int          o_errors,
    output int          o_pending
);
    import gcma_pkg::*;

    typedef struct {
        logic signed [15:0] body [3];
        logic signed [15:0] earth [3];
    } motion_t;

    // Shadow of the block's registers and filter state.
    logic [15:0]        tau_us;
    logic [14:0]        grav_q8;
    logic signed [15:0] filt_body [3];
    motion_t            motion_q [$];

    // Shift right by 28 with ties rounded away from zero.
    function automatic longint round_q28(input longint v);
        longint half;
        half = longint'(1) << 27;
        return (v >= 0) ? ((v + half) >>> 28) : -((-v + half) >>> 28);
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        return (num >= 0) ? ((num + den / 2) / den) : -((-num + den / 2) / den);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Advance the filter by one item and return the motion it gives out.
    function automatic motion_t filter_step(input longint qw, input longint qx,
                                            input longint qy, input longint qz,
                                            input longint acc [3], input longint dt);
        longint  rot [3][3];
        longint  tau, grav, diff, num, acc_sum;
        motion_t res;
        tau  = longint'(tau_us);
        grav = longint'(grav_q8);
        rot[0][0] = (longint'(1) << 28) - 2 * (qy * qy) - 2 * (qz * qz);
        rot[0][1] = 2 * (qx * qy - qw * qz);
        rot[0][2] = 2 * (qx * qz + qw * qy);
        rot[1][0] = 2 * (qx * qy + qw * qz);
        rot[1][1] = (longint'(1) << 28) - 2 * (qx * qx) - 2 * (qz * qz);
        rot[1][2] = 2 * (qy * qz - qw * qx);
        rot[2][0] = 2 * (qx * qz - qw * qy);
        rot[2][1] = 2 * (qy * qz + qw * qx);
        rot[2][2] = (longint'(1) << 28) - 2 * (qx * qx) - 2 * (qy * qy);
        // A zero time sum holds the state.
        if (tau + dt != 0) begin
            for (int i = 0; i < 3; i++) begin
                diff = acc[i] - round_q28(rot[2][i] * grav);
                num  = diff * dt + longint'(filt_body[i]) * tau;
                filt_body[i] = clamp16(round_div(num, tau + dt));
            end
        end
        for (int i = 0; i < 3; i++) begin
            acc_sum = 0;
            for (int j = 0; j < 3; j++) begin
                acc_sum += rot[i][j] * longint'(filt_body[j]);
            end
            res.body[i]  = filt_body[i];
            res.earth[i] = clamp16(round_q28(acc_sum));
        end
        return res;
    endfunction

    assign o_pending = motion_q.size();

    always @(posedge i_clk) begin
        motion_t exp_m;
        logic signed [15:0] got [6];
        longint  acc [3];
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            tau_us    <= LpfTimeReset;
            grav_q8   <= GravityReset;
            filt_body = '{default: '0};
            motion_q.delete();
            o_errors  <= 0;
        end else begin
            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgLpfTime: tau_us  <= i_cfg_data;
                    CfgGravity: grav_q8 <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            // Accepted input item.
            if (in_if.valid && in_if.ready) begin
                acc[0] = in_if.accel_x;
                acc[1] = in_if.accel_y;
                acc[2] = in_if.accel_z;
                motion_q.push_back(filter_step(in_if.quat_w, in_if.quat_x, in_if.quat_y,
                                               in_if.quat_z, acc, longint'(in_if.dt_us)));
            end
            // Accepted result item.
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.motion_body_x, out_if.motion_body_y, out_if.motion_body_z,
                        out_if.motion_earth_x, out_if.motion_earth_y,
                        out_if.motion_earth_z};
                if (motion_q.size() == 0) begin
                    $display("%0t: unexpected result item", $time);
                    errs++;
                end else begin
                    exp_m = motion_q.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if ((k < 3 ? exp_m.body[k] : exp_m.earth[k-3]) !== got[k]) begin
                            $display("%0t: field %0d expected %0d actual %0d", $time, k,
                                     (k < 3 ? exp_m.body[k] : exp_m.earth[k-3]), got[k]);
                            errs++;
                        end
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

// File: dv/tb_gravity_compensated_motion_accel_core.sv
// Testbench top for the gravity compensated motion acceleration core.
// Drives directed and random items through several register settings; gcma_scoreboard checks.
// Depends on gcma_pkg, gcma_if, gcma_scoreboard and the core.
`timescale 1ns / 100ps

module tb_gravity_compensated_motion_accel_core;
    import gcma_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;
    int                  errors;
    int                  pending;
    int                  stall_mode;

    gcma_in_if  in_if (i_clk);
    gcma_out_if out_if (i_clk);

    gravity_compensated_motion_accel_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .s_in      (in_if),
        .m_out     (out_if)
    );

    gcma_scoreboard i_scoreboard (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .in_if     (in_if),
        .out_if    (out_if),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Receiver stalls: mode 0 never stalls, 1 stalls lightly, 2 stalls heavily.
    always @(posedge i_clk) begin
        if (stall_mode == 0) begin
            out_if.ready <= 1'b1;
        end else if (stall_mode == 1) begin
            out_if.ready <= ($urandom_range(3, 0) != 0);
        end else begin
            out_if.ready <= ($urandom_range(3, 0) == 0);
        end
    end

    // Present one item and hold it until the block takes it.
    task automatic send_motion(input logic [15:0] qw, input logic [15:0] qx,
                               input logic [15:0] qy, input logic [15:0] qz,
                               input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] dt);
        in_if.valid   <= 1'b1;
        in_if.quat_w  <= qw;
        in_if.quat_x  <= qx;
        in_if.quat_y  <= qy;
        in_if.quat_z  <= qz;
        in_if.accel_x <= ax;
        in_if.accel_y <= ay;
        in_if.accel_z <= az;
        in_if.dt_us   <= dt;
        do begin
            @(negedge i_clk);
        end while (!in_if.ready);
        @(posedge i_clk);
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        // Sample the in-flight count away from the clock edge.
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [15:0] rand_quat();
        return ($urandom_range(7, 0) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(32768, 0) - 16384);
    endfunction

    function automatic logic [15:0] rand_accel();
        return ($urandom_range(3, 0) == 0) ? 16'($urandom)
                                          : 16'($urandom_range(8000, 0) - 4000);
    endfunction

    function automatic logic [15:0] rand_dt();
        int pick;
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
            return 16'd0;
        end
        if (pick == 1) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(20000, 1));
    endfunction

    // Random items in bursts with gaps.
    task automatic random_burst_run(input int count);
        int burst;
        int left;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(8, 1);
            stall_mode = $urandom_range(2, 0);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_motion(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                            rand_accel(), rand_accel(), rand_accel(), rand_dt());
                left--;
            end
            in_if.valid <= 1'b0;
            repeat ($urandom_range(40, 0)) @(posedge i_clk);
        end
    endtask

    initial begin
        #25_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        stall_mode    = 0;
        in_if.valid   = 1'b0;
        in_if.quat_w  = '0;
        in_if.quat_x  = '0;
        in_if.quat_y  = '0;
        in_if.quat_z  = '0;
        in_if.accel_x = '0;
        in_if.accel_y = '0;
        in_if.accel_z = '0;
        in_if.dt_us   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings.
        send_motion(16'd16384, 0, 0, 0, 0, 0, 16'd2511, 16'd1000);
        send_motion(0, 0, 0, 0, 0, 0, 0, 0);
        send_motion(16'd16384, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_motion(16'hC000, 16'hC000, 16'hC000, 16'hC000, 16'h8000, 16'h7FFF,
                    16'h8000, 16'hFFFF);
        send_motion(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB,
                    16'h0F0F, 16'd5000);
        send_motion(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                    16'h7FFF, 16'd8500);
        send_motion(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'd1);
        send_motion(0, 16'd16384, 0, 0, 16'd300, 16'd300, 16'd300, 16'd10000);
        send_motion(0, 0, 16'd16384, 0, 16'd300, 16'hFED4, 16'd300, 16'd10000);
        send_motion(0, 0, 0, 16'd16384, 16'd100, 16'd100, 16'hFFFF, 16'd3000);
        in_if.valid <= 1'b0;
        random_burst_run(90);

        // Zero time constant: dt of zero holds the state, large pushes saturate it.
        write_reg(CfgLpfTime, 16'd0);
        write_reg(CfgGravity, 16'hFFFF);
        send_motion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                    16'h7FFF, 16'd1);
        send_motion(16'd16384, 0, 0, 0, 16'h1111, 16'h2222, 16'h3333, 16'd0);
        send_motion(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                    16'h8000, 16'd7);
        send_motion(0, 0, 0, 0, 0, 0, 0, 0);
        in_if.valid <= 1'b0;
        random_burst_run(90);

        write_reg(CfgLpfTime, 16'hFFFF);
        write_reg(CfgGravity, 16'd0);
        send_motion(16'd16384, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1);
        in_if.valid <= 1'b0;
        random_burst_run(100);

        write_reg(CfgLpfTime, 16'($urandom));
        write_reg(CfgGravity, 16'($urandom_range(32767, 0)));
        random_burst_run(100);

        write_reg(CfgLpfTime, 16'd1);
        write_reg(CfgGravity, 16'd2511);
        random_burst_run(100);

        // Drain, then allow for one more result's worth of cycles.
        stall_mode = 1;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
